>>> rtl/core/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
package srsw_pkg;

    localparam int SEQ_BITS     = 3;
    localparam int SLOT_BITS    = 2;
    localparam int PAYLOAD_BITS = 32;
    localparam int WINDOW_SLOTS = 4;

    // request kinds
    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_SENT         = 3'd0;
    localparam logic [2:0] ST_FULL         = 3'd1;
    localparam logic [2:0] ST_RESENT       = 3'd2;
    localparam logic [2:0] ST_ACK_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_ACK_IGNORED  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT_IDLE = 3'd5;

    typedef struct packed {
        logic [1:0]              action;
        logic [PAYLOAD_BITS-1:0] payload_word;
        logic [SEQ_BITS-1:0]     ack_number;
        logic                    ack_intact;
        logic [SLOT_BITS-1:0]    expired_slot;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic [SEQ_BITS-1:0]     packet_seq;
        logic [PAYLOAD_BITS-1:0] packet_payload;
        logic [SLOT_BITS-1:0]    timer_slot;
        logic [SEQ_BITS-1:0]     window_base;
        logic [SEQ_BITS-1:0]     next_sequence;
        logic                    window_full;
    } t_out;

    // one slot of the retransmit buffer
    typedef struct packed {
        logic [SEQ_BITS-1:0]     seq;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

endpackage

>>> rtl/core/srsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window: send, ack and timeout handling over a
// four-slot retransmit buffer. Each request passes a capture step and an
// update step: the capture step registers it and, on a timeout, reads the
// named slot of the buffer RAM, whose read data is registered; the update
// step changes base, next sequence and acked marks, writes the buffer on a
// send and loads the result register. A new request is taken only after the last one's update; a
// result held by output stall delays that update until the result register frees up.
module selective_repeat_sender_window import srsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic                    r_busy;
    t_in                     r_req;
    logic                    r_out_valid;
    t_out                    r_out;
    logic [SEQ_BITS-1:0]     r_base;
    logic [SEQ_BITS-1:0]     r_next;
    logic [WINDOW_SLOTS-1:0] r_marks;

    logic [SEQ_BITS-1:0]     n_base;
    logic [SEQ_BITS-1:0]     n_next;
    logic [WINDOW_SLOTS-1:0] n_marks;
    t_out                    n_res;

    logic                    in_acc;
    logic                    step;
    logic                    rd_en;
    logic                    wr_req;
    t_entry                  wr_data;
    t_entry                  rd_data;
    logic [SLOT_BITS-1:0]    send_slot;
    logic [SLOT_BITS-1:0]    ack_slot;
    logic [SEQ_BITS-1:0]     ack_dist;
    logic                    cur_full;
    logic                    ack_ok;

    assign in_acc = i_in_valid && !r_busy;
    assign step   = r_busy && (!r_out_valid || !i_out_stall);
    assign rd_en  = in_acc && (i_in_data.action == ACT_TIMEOUT);

    assign send_slot = r_next[SLOT_BITS-1:0];
    assign ack_slot  = r_req.ack_number[SLOT_BITS-1:0];
    assign ack_dist  = r_req.ack_number - r_base;
    assign cur_full  = (r_next == r_base + SEQ_BITS'(WINDOW_SLOTS));
    assign ack_ok    = r_req.ack_intact && (ack_dist < SEQ_BITS'(WINDOW_SLOTS));

    assign wr_data.seq     = r_next;
    assign wr_data.payload = r_req.payload_word;

    srsw_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (WINDOW_SLOTS)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (step && wr_req),
        .i_wr_addr (send_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_in_data.expired_slot),
        .o_rd_data (rd_data)
    );

    always_comb begin
        logic [SEQ_BITS-1:0] scan_seq;
        logic                scan_go;
        n_base   = r_base;
        n_next   = r_next;
        n_marks  = r_marks;
        n_res    = '0;
        wr_req   = 1'b0;
        scan_seq = r_base;
        scan_go  = 1'b1;
        n_res.status = ST_ACK_IGNORED;
        unique case (r_req.action)
            ACT_SEND: begin
                if (cur_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    wr_req                 = 1'b1;
                    n_marks[send_slot]     = 1'b0;
                    n_res.packet_seq       = r_next;
                    n_res.packet_payload   = r_req.payload_word;
                    n_res.timer_slot       = send_slot;
                    n_next                 = r_next + 1'b1;
                    n_res.status           = ST_SENT;
                end
            end
            ACT_ACK: begin
                if (ack_ok) begin
                    n_marks[ack_slot] = 1'b1;
                    // slide base over consecutive acked slots, stop at next_seq
                    for (int k = 0; k < WINDOW_SLOTS; k++) begin
                        scan_seq = r_base + SEQ_BITS'(k);
                        if (scan_go && (scan_seq != r_next)
                            && n_marks[scan_seq[SLOT_BITS-1:0]]) begin
                            n_marks[scan_seq[SLOT_BITS-1:0]] = 1'b0;
                            n_base = scan_seq + 1'b1;
                        end else begin
                            scan_go = 1'b0;
                        end
                    end
                    n_res.timer_slot = ack_slot;
                    n_res.status     = ST_ACK_ACCEPTED;
                end
            end
            ACT_TIMEOUT: begin
                // slot field cannot exceed the window, only the empty case idles
                if (r_next == r_base) begin
                    n_res.status = ST_TIMEOUT_IDLE;
                end else begin
                    n_res.packet_seq     = rd_data.seq;
                    n_res.packet_payload = rd_data.payload;
                    n_res.timer_slot     = r_req.expired_slot;
                    n_res.status         = ST_RESENT;
                end
            end
            default: begin
                n_res.status = ST_ACK_IGNORED;
            end
        endcase
        n_res.window_base   = n_base;
        n_res.next_sequence = n_next;
        n_res.window_full   = (n_next == n_base + SEQ_BITS'(WINDOW_SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_next      <= '0;
            r_marks     <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (step) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                r_base  <= n_base;
                r_next  <= n_next;
                r_marks <= n_marks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_data;
        end
        if (step) begin
            r_out <= n_res;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/srsw_check.sv
// Port-level checks for the selective-repeat sender window, bound to the top.
module srsw_check import srsw_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // a taken request keeps the input side busy for its update cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.window_full ==
            (o_out_data.next_sequence ==
             o_out_data.window_base + SEQ_BITS'(WINDOW_SLOTS))))
        else $error("window_full inconsistent with base and next");

    a_no_packet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL
            || o_out_data.status == ST_ACK_IGNORED
            || o_out_data.status == ST_TIMEOUT_IDLE))
        |-> (o_out_data.packet_seq == '0 && o_out_data.packet_payload == '0
             && o_out_data.timer_slot == '0))
        else $error("packet or timer fields set without a packet");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind selective_repeat_sender_window srsw_check u_srsw_check (.*);

>>> verif/srsw_checker.sv
// Checker for the selective-repeat sender window: predicts each result and compares it.
`timescale 1ns / 100ps

module srsw_checker import srsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int SHOWN_MISMATCHES = 10;
    localparam logic [SEQ_BITS-1:0] WIN_SPAN = SEQ_BITS'(WINDOW_SLOTS);

    // predictor copy of the window state
    logic [SEQ_BITS-1:0]     base_seq_m;
    logic [SEQ_BITS-1:0]     next_seq_m;
    logic                    acked[WINDOW_SLOTS];
    logic [PAYLOAD_BITS-1:0] held_payload[WINDOW_SLOTS];
    logic [SEQ_BITS-1:0]     held_seq[WINDOW_SLOTS];

    t_out awaited_results[$];
    int   fails   = 0;
    int   checked = 0;

    function automatic string show_result(input t_out r);
        return $sformatf("status=%0d seq=%0d payload=%08h tslot=%0d base=%0d next=%0d full=%0d",
                         r.status, r.packet_seq, r.packet_payload, r.timer_slot,
                         r.window_base, r.next_sequence, r.window_full);
    endfunction

    // Applies one request to the predicted window and returns its result.
    function automatic t_out window_step(input t_in req);
        t_out                rsp;
        logic [SEQ_BITS-1:0] scan;
        logic [SEQ_BITS-1:0] ack_gap;
        logic [SLOT_BITS-1:0] slot;
        rsp = '0;
        rsp.status = ST_ACK_IGNORED;
        case (req.action)
            ACT_SEND: begin
                if (next_seq_m == base_seq_m + WIN_SPAN) begin
                    rsp.status = ST_FULL;
                end else begin
                    slot = next_seq_m[SLOT_BITS-1:0];
                    held_seq[slot]     = next_seq_m;
                    held_payload[slot] = req.payload_word;
                    acked[slot]        = 1'b0;
                    rsp.packet_seq     = next_seq_m;
                    rsp.packet_payload = req.payload_word;
                    rsp.timer_slot     = slot;
                    rsp.status         = ST_SENT;
                    next_seq_m         = next_seq_m + 1'b1;
                end
            end
            ACT_ACK: begin
                ack_gap = req.ack_number - base_seq_m;
                if (req.ack_intact && ack_gap < WIN_SPAN) begin
                    acked[req.ack_number[SLOT_BITS-1:0]] = 1'b1;
                    // slide over consecutive acked slots; at most one pass per slot
                    scan = base_seq_m;
                    while (scan != next_seq_m && acked[scan[SLOT_BITS-1:0]]) begin
                        acked[scan[SLOT_BITS-1:0]] = 1'b0;
                        scan = scan + 1'b1;
                        base_seq_m = scan;
                    end
                    rsp.timer_slot = req.ack_number[SLOT_BITS-1:0];
                    rsp.status     = ST_ACK_ACCEPTED;
                end
            end
            ACT_TIMEOUT: begin
                if (next_seq_m == base_seq_m) begin
                    rsp.status = ST_TIMEOUT_IDLE;
                end else begin
                    rsp.packet_seq     = held_seq[req.expired_slot];
                    rsp.packet_payload = held_payload[req.expired_slot];
                    rsp.timer_slot     = req.expired_slot;
                    rsp.status         = ST_RESENT;
                end
            end
            default: ;
        endcase
        rsp.window_base   = base_seq_m;
        rsp.next_sequence = next_seq_m;
        rsp.window_full   = (next_seq_m == base_seq_m + WIN_SPAN);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_out  want;
        string bad_fields;
        if (!i_rst_n) begin
            base_seq_m = '0;
            next_seq_m = '0;
            for (int s = 0; s < WINDOW_SLOTS; s++) begin
                acked[s]        = 1'b0;
                held_payload[s] = '0;
                held_seq[s]     = '0;
            end
            awaited_results.delete();
        end else begin
            // retire the oldest expectation before adding one for a new request
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= SHOWN_MISMATCHES)
                        $display("ERROR %0t: result with none awaited: %s",
                                 $realtime, show_result(i_out_data));
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    bad_fields = "";
                    if (want.status !== i_out_data.status)
                        bad_fields = {bad_fields, " status"};
                    if (want.packet_seq !== i_out_data.packet_seq)
                        bad_fields = {bad_fields, " packet_seq"};
                    if (want.packet_payload !== i_out_data.packet_payload)
                        bad_fields = {bad_fields, " packet_payload"};
                    if (want.timer_slot !== i_out_data.timer_slot)
                        bad_fields = {bad_fields, " timer_slot"};
                    if (want.window_base !== i_out_data.window_base)
                        bad_fields = {bad_fields, " window_base"};
                    if (want.next_sequence !== i_out_data.next_sequence)
                        bad_fields = {bad_fields, " next_sequence"};
                    if (want.window_full !== i_out_data.window_full)
                        bad_fields = {bad_fields, " window_full"};
                    if (bad_fields != "") begin
                        fails++;
                        if (fails <= SHOWN_MISMATCHES)
                            $display("ERROR %0t: mismatch in%s\n  expected %s\n  actual   %s",
                                     $realtime, bad_fields, show_result(want),
                                     show_result(i_out_data));
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(window_step(i_in_data));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
    end

endmodule

>>> verif/tb.sv
// Testbench top for the selective-repeat sender window: reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import srsw_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;
    localparam int IDLE_PCT     = 21;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int fail_count;
    int pending;
    int checked;
    int cycles    = 0;
    int send_reqs = 0;
    int n_send    = 0;
    int n_ack     = 0;
    int n_tmo     = 0;
    int n_unused  = 0;
    bit quiet     = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    selective_repeat_sender_window DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    srsw_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // result side back-pressure
    always @(posedge i_clk)
        out_stall <= i_rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in make_req(input logic [1:0] action, input logic [31:0] payload,
                                     input logic [2:0] ack, input logic intact,
                                     input logic [1:0] slot);
        t_in r;
        r.action       = action;
        r.payload_word = payload;
        r.ack_number   = ack;
        r.ack_intact   = intact;
        r.expired_slot = slot;
        return r;
    endfunction

    // Once a send has gone out, timeouts stay on slots already written: until four
    // sends have gone out, only the lowest slots hold a packet.
    function automatic t_in random_req();
        int          pick;
        logic [1:0]  slot;
        pick = $urandom_range(99);
        if (send_reqs == 0 || send_reqs >= WINDOW_SLOTS)
            slot = $urandom_range(WINDOW_SLOTS - 1);
        else
            slot = $urandom_range(send_reqs - 1);
        if (pick < 45)
            return make_req(ACT_SEND, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 80)
            return make_req(ACT_ACK, $urandom, $urandom_range(7),
                            $urandom_range(9) != 0, $urandom);
        else if (pick < 95)
            return make_req(ACT_TIMEOUT, $urandom, $urandom, $urandom, slot);
        else
            return make_req(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic issue(input t_in req);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        case (req.action)
            ACT_SEND:    begin n_send++; if (send_reqs < WINDOW_SLOTS) send_reqs++; end
            ACT_ACK:     n_ack++;
            ACT_TIMEOUT: n_tmo++;
            default:     n_unused++;
        endcase
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    initial begin
        t_in req;
        int  useful;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window: timeouts idle, an in-window ack only marks, unused action
        issue(make_req(ACT_TIMEOUT, $urandom, $urandom, $urandom, 2'd0));
        issue(make_req(ACT_TIMEOUT, $urandom, $urandom, $urandom, 2'd3));
        issue(make_req(ACT_ACK, $urandom, 3'd0, 1'b1, $urandom));
        issue(make_req(ACT_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1, 2'd3));
        // fill the window with extreme payloads, then get refused
        issue(make_req(ACT_SEND, 32'h0000_0000, 3'd7, 1'b1, 2'd3));
        issue(make_req(ACT_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0, 2'd0));
        issue(make_req(ACT_SEND, 32'hA5A5_A5A5, 3'd5, 1'b1, 2'd1));
        issue(make_req(ACT_SEND, 32'h5A5A_5A5A, 3'd2, 1'b0, 2'd2));
        issue(make_req(ACT_SEND, 32'h1234_5678, 3'd1, 1'b1, 2'd1));
        // resend every slot
        for (int s = 0; s < WINDOW_SLOTS; s++)
            issue(make_req(ACT_TIMEOUT, $urandom, $urandom, $urandom, s[1:0]));
        // corrupt ack, acks just outside the window
        issue(make_req(ACT_ACK, $urandom, 3'd0, 1'b0, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd4, 1'b1, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd7, 1'b1, $urandom));
        // out-of-order acks, base moves only when the oldest arrives
        issue(make_req(ACT_ACK, $urandom, 3'd2, 1'b1, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd1, 1'b1, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd0, 1'b1, $urandom));
        // send past the slot count into reused slots, then drain the window
        issue(make_req(ACT_SEND, $urandom, $urandom, $urandom, $urandom));
        issue(make_req(ACT_SEND, $urandom, $urandom, $urandom, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd3, 1'b1, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd5, 1'b1, $urandom));
        issue(make_req(ACT_ACK, $urandom, 3'd4, 1'b1, $urandom));
        issue(make_req(ACT_TIMEOUT, $urandom, $urandom, $urandom, 2'd1));

        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            quiet = (useful >= QUIET_FROM && useful < QUIET_TO);
            req = random_req();
            issue(req);
            if (req.action != ACT_UNUSED && !(req.action == ACT_ACK && !req.ack_intact))
                useful++;
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d requests (%0d send, %0d ack, %0d timeout, %0d unused action)",
                 n_send + n_ack + n_tmo + n_unused, n_send, n_ack, n_tmo, n_unused);
        $display("Summary: %0d results compared, %0d failures", checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/srsw_pkg.sv
rtl/core/srsw_ram.sv
rtl/core/selective_repeat_sender_window.sv
rtl/core/srsw_check.sv
verif/srsw_checker.sv
verif/tb.sv
